// ----- sv/pcpd_pkg.sv -----
`default_nettype none

package pcpd_pkg;

  // Table geometry.
  localparam int SLOTS = 16;
  localparam int DEPTH = 128;

  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HEAD_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CAP_W   = 8;
  localparam int DADDR_W = $clog2(SLOTS * DEPTH);

  // Field widths.
  localparam int ID_W    = 22;
  localparam int LEN_W   = 16;
  localparam int VAL_W   = 32;
  localparam int BYTES_W = 9;
  localparam int CMP_W   = 9;

  localparam logic [BYTES_W-1:0] LEN_CLAMP     = BYTES_W'(256);
  localparam logic [CAP_W-1:0]   CAP_LIMIT_RST = CAP_W'(100);
  localparam logic [BYTES_W-1:0] SETUP_BYTES   = BYTES_W'(1);
  localparam logic [BYTES_W-1:0] DATA_BYTES    = BYTES_W'(4);

  // Request codes.
  localparam logic [1:0] MODE_OPEN  = 2'd0;
  localparam logic [1:0] MODE_CLOSE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_WRITE = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  typedef enum logic [1:0] {
    PH_FREE    = 2'd0,
    PH_OPEN    = 2'd1,
    PH_SETUP   = 2'd2,
    PH_WRITTEN = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_POP
  } state_t;

  // Per-slot deque bookkeeping held in the slot RAM.
  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [CNT_W-1:0]  count;
    logic [CAP_W-1:0]  cap;
  } slot_rec_t;

endpackage

`default_nettype wire

// ----- sv/pcpd_ram.sv -----
`default_nettype none

module pcpd_ram #(
  parameter int WIDTH = 32,
  parameter int WORDS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(WORDS)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(WORDS)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/per_client_parity_deque.sv -----
`default_nettype none

// Per-client parity deque. Up to SLOTS clients each own one bounded deque of
// 32-bit values. An open item claims the lowest free slot for a requester that
// holds none, and a close item frees the requester's slot. The first write
// after open is a one-byte set-up that fixes the capacity (1 up to the smaller
// of cfg_wdata's register and DEPTH) and empties the deque; later writes must
// be four bytes, odd values go to the front and even values to the rear. A
// read pops the front. Every item yields exactly one result carrying a status,
// the popped value (zero but for a successful read) and a byte count: the
// request length clamped to 256 for a successful read or write, else zero. The
// block handles one item at a time and stalls its input until it is done; the
// steps are look-up, decision and, for a successful read, pop, because the
// deque's head pointer must come out of the slot RAM before the entry RAM can
// be addressed. A result held by out_stall keeps the sequencer waiting in its
// decision or pop step. Both RAMs have a registered read. The slot owner and
// phase live in flip flops so that the requester lookup is a parallel compare.
// A finished result sits in an output register, so the next item can be
// accepted while it waits to be taken. The input is stalled during reset. The
// entry RAM needs no clearing: a read only ever pops entries that were written.
module per_client_parity_deque
  import pcpd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               cfg_we,
  input  wire logic [CAP_W-1:0]   cfg_wdata,

  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [1:0]         in_mode,
  input  wire logic [ID_W-1:0]    in_requester_id,
  input  wire logic [LEN_W-1:0]   in_request_length,
  input  wire logic [VAL_W-1:0]   in_write_value,

  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [1:0]         out_status,
  output      logic [VAL_W-1:0]   out_read_value,
  output      logic [BYTES_W-1:0] out_byte_count
);

  // Control state.
  state_t            state_r, state_nxt;
  logic [CAP_W-1:0]  cap_limit_r;
  phase_t            phase_r [SLOTS];
  logic [ID_W-1:0]   owner_r [SLOTS];

  // The accepted item and its lookup results.
  logic [1:0]        mode_r;
  logic [ID_W-1:0]   id_r;
  logic [LEN_W-1:0]  len_r;
  logic [VAL_W-1:0]  wval_r;
  logic              own_hit_r, free_hit_r;
  logic [SLOT_W-1:0] own_slot_r, free_slot_r;

  // Output register.
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [VAL_W-1:0]   out_read_value_r;
  logic [BYTES_W-1:0] out_byte_count_r;

  // Lookup over the slot table.
  logic              own_hit, free_hit;
  logic [SLOT_W-1:0] own_slot, free_slot;

  // RAM ports.
  logic              srm_we, srm_re;
  slot_rec_t         srm_wdata, srm_rdata;
  logic              dram_we, dram_re;
  logic [DADDR_W-1:0] dram_waddr, dram_raddr;
  logic [VAL_W-1:0]  dram_rdata;

  // Slot table update from the decision logic.
  logic              tab_we;
  logic [SLOT_W-1:0] tab_slot;
  phase_t            tab_phase;
  logic [ID_W-1:0]   tab_owner;

  // Result load.
  logic               out_load;
  logic [1:0]         res_status;
  logic [VAL_W-1:0]   res_value;
  logic [BYTES_W-1:0] res_bytes;

  logic               accept, out_free;
  logic [BYTES_W-1:0] clamped;

  assign accept   = in_valid && !in_stall;
  assign in_stall = !rst_n || (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign clamped  = (len_r > LEN_W'(LEN_CLAMP)) ? LEN_CLAMP : len_r[BYTES_W-1:0];

  // Lowest slot owned by the requester and lowest free slot. Owners are
  // unique among busy slots, so only the free search really needs priority.
  always_comb begin
    own_hit   = 1'b0;
    own_slot  = '0;
    free_hit  = 1'b0;
    free_slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (phase_r[s] != PH_FREE && owner_r[s] == in_requester_id) begin
        own_hit  = 1'b1;
        own_slot = SLOT_W'(s);
      end
      if (phase_r[s] == PH_FREE) begin
        free_hit  = 1'b1;
        free_slot = SLOT_W'(s);
      end
    end
  end

  pcpd_ram #(
    .WIDTH ($bits(slot_rec_t)),
    .WORDS (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (srm_we),
    .waddr (own_slot_r),
    .wdata (srm_wdata),
    .re    (srm_re),
    .raddr (own_slot),
    .rdata (srm_rdata)
  );

  pcpd_ram #(
    .WIDTH (VAL_W),
    .WORDS (SLOTS * DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (dram_we),
    .waddr (dram_waddr),
    .wdata (wval_r),
    .re    (dram_re),
    .raddr (dram_raddr),
    .rdata (dram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_limit_r <= CAP_LIMIT_RST;
      out_valid_r <= 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        phase_r[s] <= PH_FREE;
        owner_r[s] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cap_limit_r <= cfg_wdata;
      end
      if (tab_we) begin
        phase_r[tab_slot] <= tab_phase;
        owner_r[tab_slot] <= tab_owner;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r      <= in_mode;
      id_r        <= in_requester_id;
      len_r       <= in_request_length;
      wval_r      <= in_write_value;
      own_hit_r   <= own_hit;
      own_slot_r  <= own_slot;
      free_hit_r  <= free_hit;
      free_slot_r <= free_slot;
    end
    if (out_load) begin
      out_status_r     <= res_status;
      out_read_value_r <= res_value;
      out_byte_count_r <= res_bytes;
    end
  end

  // Sequencer: look up the slot record, decide and write back, and for a
  // successful read go on to a pop step that loads the popped entry.
  always_comb begin
    slot_rec_t           rec;
    phase_t              ph;
    logic [HEAD_W:0]     sum;
    logic [HEAD_W-1:0]   idx, head_inc, head_dec;
    logic [CAP_W-1:0]    cap;
    logic [DADDR_W-1:0]  base;

    rec      = srm_rdata;
    ph       = phase_r[own_slot_r];
    base     = DADDR_W'(own_slot_r) * DADDR_W'(DEPTH);
    head_inc = (rec.head == HEAD_W'(DEPTH - 1)) ? '0 : rec.head + 1'b1;
    head_dec = (rec.head == '0) ? HEAD_W'(DEPTH - 1) : rec.head - 1'b1;
    sum      = (HEAD_W + 1)'(rec.head) + (HEAD_W + 1)'(rec.count);
    idx      = (sum >= (HEAD_W + 1)'(DEPTH)) ? HEAD_W'(sum - (HEAD_W + 1)'(DEPTH))
                                             : HEAD_W'(sum);
    cap      = wval_r[CAP_W-1:0];

    state_nxt  = state_r;
    srm_re     = 1'b0;
    srm_we     = 1'b0;
    srm_wdata  = rec;
    dram_we    = 1'b0;
    dram_waddr = base + DADDR_W'(idx);
    dram_re    = 1'b0;
    dram_raddr = base + DADDR_W'(rec.head);
    tab_we     = 1'b0;
    tab_slot   = own_slot_r;
    tab_phase  = ph;
    tab_owner  = owner_r[own_slot_r];
    out_load   = 1'b0;
    res_status = ST_INVALID;
    res_value  = '0;
    res_bytes  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          srm_re    = 1'b1;
          state_nxt = S_LOOK;
        end
      end

      S_LOOK: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          case (mode_r)
            MODE_OPEN: begin
              if (!own_hit_r && free_hit_r) begin
                tab_we     = 1'b1;
                tab_slot   = free_slot_r;
                tab_phase  = PH_OPEN;
                tab_owner  = id_r;
                res_status = ST_OK;
              end
            end
            MODE_CLOSE: begin
              if (own_hit_r) begin
                tab_we     = 1'b1;
                tab_phase  = PH_FREE;
                tab_owner  = '0;
                res_status = ST_OK;
              end
            end
            MODE_READ: begin
              if (own_hit_r && len_r != '0) begin
                if (ph == PH_OPEN || rec.count == '0) begin
                  res_status = ST_REFUSED;
                end else begin
                  // Pop: the result is loaded once the entry comes back.
                  dram_re         = 1'b1;
                  srm_we          = 1'b1;
                  srm_wdata.head  = head_inc;
                  srm_wdata.count = rec.count - 1'b1;
                  out_load        = 1'b0;
                  state_nxt       = S_POP;
                end
              end
            end
            default: begin
              if (own_hit_r && len_r != '0) begin
                if (ph == PH_OPEN) begin
                  // Set-up write: one byte carrying the capacity.
                  if (clamped == SETUP_BYTES && cap != '0 && cap <= cap_limit_r &&
                      CMP_W'(cap) <= CMP_W'(DEPTH)) begin
                    srm_we          = 1'b1;
                    srm_wdata.head  = '0;
                    srm_wdata.count = '0;
                    srm_wdata.cap   = cap;
                    tab_we          = 1'b1;
                    tab_phase       = PH_SETUP;
                    res_status      = ST_OK;
                    res_bytes       = clamped;
                  end
                end else if (clamped == DATA_BYTES) begin
                  if (CMP_W'(rec.count) >= CMP_W'(rec.cap) ||
                      CMP_W'(rec.count) >= CMP_W'(DEPTH)) begin
                    res_status = ST_REFUSED;
                  end else begin
                    // Odd values go in ahead of the head, even ones behind the tail.
                    dram_we = 1'b1;
                    if (wval_r[0]) begin
                      dram_waddr     = base + DADDR_W'(head_dec);
                      srm_wdata.head = head_dec;
                    end
                    srm_we          = 1'b1;
                    srm_wdata.count = rec.count + 1'b1;
                    tab_we          = 1'b1;
                    tab_phase       = PH_WRITTEN;
                    res_status      = ST_OK;
                    res_bytes       = clamped;
                  end
                end
              end
            end
          endcase
        end
      end

      S_POP: begin
        if (out_free) begin
          out_load   = 1'b1;
          res_status = ST_OK;
          res_value  = dram_rdata;
          res_bytes  = clamped;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;
  assign out_byte_count = out_byte_count_r;

  // A deque entry is only written into a slot that some client holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    dram_we |-> phase_r[own_slot_r] != PH_FREE)
    else $error("entry write into a free slot");

  // A new result never overwrites one that is still waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten");

  // Results appear only after the decision or the pop step.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_LOOK || $past(state_r) == S_POP))
    else $error("result without a finished item");

endmodule

`default_nettype wire
